// ===== rtl/wteg_pkg.sv =====
// Shared types, constants, the increment table and a decay level helper for the wavetable envelope generator.
// Used by the controller, the datapath, the top level and the checker.
package wteg_pkg;

  localparam int NUM_SLOTS = 24;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int SET_W     = 29;
  localparam int ATT_W     = 9;
  localparam int EG_CNT_W  = 15;
  localparam int INC_STEPS = 8;

  localparam logic [ATT_W-1:0]  MAX_ATTEN = 9'h1FF;
  localparam logic [CNT_W-1:0]  SLOT_END  = CNT_W'(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // Input item kinds.
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_STORE   = 2'd1;
  localparam logic [1:0] MODE_KEY_ON  = 2'd2;
  localparam logic [1:0] MODE_KEY_OFF = 2'd3;

  // Envelope phase codes.
  localparam logic [2:0] PH_OFF     = 3'd0;
  localparam logic [2:0] PH_RELEASE = 3'd1;
  localparam logic [2:0] PH_SUSTAIN = 3'd2;
  localparam logic [2:0] PH_DECAY   = 3'd3;
  localparam logic [2:0] PH_ATTACK  = 3'd4;

  typedef struct packed {
    logic [SLOT_W-1:0] addr;
    logic              store;
    logic              key_on;
    logic              key_off;
    logic              tick;
    logic              a_load;
    logic              b_step;
  } wteg_cmd_t;

  // Increment rows, indexed by {row, step}.
  localparam logic [2:0] INC_TABLE [13 * INC_STEPS] = '{
    3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1,
    3'd0, 3'd1, 3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1,
    3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1, 3'd1, 3'd1,
    3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2,
    3'd1, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2,
    3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd4, 3'd2, 3'd2, 3'd2, 3'd4,
    3'd2, 3'd4, 3'd2, 3'd4, 3'd2, 3'd4, 3'd2, 3'd4,
    3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  // Decay level in attenuation units; the top code jumps to 496.
  function automatic logic [ATT_W-1:0] decay_level(input logic [3:0] code);
    logic [ATT_W-1:0] lvl;
    if (code == 4'd15) begin
      lvl = 9'd496;
    end else begin
      lvl = {1'b0, code, 4'b0000};
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/wteg_ctrl.sv =====
// Controller for the wavetable envelope generator: item decode and the
// slot sweep sequencer. Depends on wteg_pkg.
module wteg_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [1:0]              in_mode,
  input  logic [4:0]              in_slot,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output wteg_pkg::wteg_cmd_t     cmd
);

  typedef enum logic {ST_IDLE, ST_SWEEP} state_t;

  state_t                       state_r, state_nxt;
  logic [wteg_pkg::CNT_W-1:0]   a_idx_r, a_idx_nxt;
  logic                         b_vld_r, b_vld_nxt;
  logic                         out_vld_r, out_vld_nxt;
  logic                         acc;
  logic                         adv;
  logic                         slot_ok;
  logic                         a_more;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign acc        = in_tvalid && in_tready;
  assign adv        = !out_vld_r || out_tready;
  assign slot_ok    = 32'(in_slot) < 32'(wteg_pkg::NUM_SLOTS);
  assign a_more     = a_idx_r < wteg_pkg::SLOT_END;

  always_comb begin
    state_nxt   = state_r;
    a_idx_nxt   = a_idx_r;
    b_vld_nxt   = b_vld_r;
    cmd         = '0;
    cmd.addr    = (state_r == ST_IDLE) ? wteg_pkg::SLOT_W'(in_slot)
                                       : a_idx_r[wteg_pkg::SLOT_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_mode == wteg_pkg::MODE_TICK) begin
            cmd.tick  = 1'b1;
            a_idx_nxt = '0;
            b_vld_nxt = 1'b0;
            state_nxt = ST_SWEEP;
          end else if (slot_ok) begin
            cmd.store   = (in_mode == wteg_pkg::MODE_STORE);
            cmd.key_on  = (in_mode == wteg_pkg::MODE_KEY_ON);
            cmd.key_off = (in_mode == wteg_pkg::MODE_KEY_OFF);
          end
        end
      end
      ST_SWEEP: begin
        // Stage A reads slot a_idx while stage B finishes the slot before it.
        if (adv) begin
          cmd.b_step = b_vld_r;
          cmd.a_load = a_more;
          b_vld_nxt  = a_more;
          if (a_more) begin
            a_idx_nxt = a_idx_r + 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_vld_nxt = cmd.b_step ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      a_idx_r   <= '0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      a_idx_r   <= a_idx_nxt;
      b_vld_r   <= b_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// ===== rtl/wteg_dp.sv =====
// Datapath for the wavetable envelope generator: per-slot state, the
// two-stage slot step and the result register. Depends on wteg_pkg.
module wteg_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wteg_pkg::wteg_cmd_t              cmd,
  input  logic [wteg_pkg::SET_W-1:0]       in_settings,
  output logic [4:0]                       out_slot,
  output logic [wteg_pkg::ATT_W-1:0]       out_atten,
  output logic [2:0]                       out_phase,
  output logic                             out_active,
  output logic                             out_last
);

  logic [wteg_pkg::SET_W-1:0]    set_r    [wteg_pkg::NUM_SLOTS];
  logic [wteg_pkg::ATT_W-1:0]    atten_r  [wteg_pkg::NUM_SLOTS];
  logic [2:0]                    phase_r  [wteg_pkg::NUM_SLOTS];
  logic                          active_r [wteg_pkg::NUM_SLOTS];
  logic [wteg_pkg::EG_CNT_W-1:0] cnt_r;

  // Stage A registers.
  logic [wteg_pkg::SLOT_W-1:0]   idx_b_r;
  logic [5:0]                    rate_r;
  logic [2:0]                    ph_b_r;
  logic [wteg_pkg::ATT_W-1:0]    att_b_r;
  logic [wteg_pkg::ATT_W-1:0]    lvl_b_r;
  logic                          act_b_r;

  // Result register.
  logic [4:0]                    o_slot_r;
  logic [wteg_pkg::ATT_W-1:0]    o_att_r;
  logic [2:0]                    o_ph_r;
  logic                          o_act_r;
  logic                          o_last_r;

  // Stage A signals.
  logic [wteg_pkg::SET_W-1:0]    s_a;
  logic [2:0]                    ph_a;
  logic [3:0]                    code_a;
  logic [3:0]                    rc_a;
  logic signed [7:0]             raw_a;
  logic [5:0]                    rate_a;

  // Stage B signals.
  logic [3:0]                    shift_b;
  logic [wteg_pkg::EG_CNT_W-1:0] mask_b;
  logic [wteg_pkg::EG_CNT_W-1:0] cnt_sh_b;
  logic [2:0]                    sel_b;
  logic [5:0]                    r_m52_b;
  logic [3:0]                    row_b;
  logic [2:0]                    inc_b;
  logic [3:0]                    inc2_b;
  logic                          hold_b;
  logic [9:0]                    vp1_b;
  logic [12:0]                   prod_b;
  logic [9:0]                    dec_b;
  logic [9:0]                    add_b;
  logic [wteg_pkg::ATT_W-1:0]    att_nxt;
  logic [2:0]                    ph_nxt;
  logic                          act_nxt;

  assign s_a  = set_r[cmd.addr];
  assign ph_a = phase_r[cmd.addr];
  assign rc_a = s_a[19:16];

  always_comb begin
    case (ph_a)
      wteg_pkg::PH_ATTACK:  code_a = s_a[3:0];
      wteg_pkg::PH_DECAY:   code_a = s_a[7:4];
      wteg_pkg::PH_SUSTAIN: code_a = s_a[15:12];
      wteg_pkg::PH_RELEASE: code_a = s_a[23:20];
      default:              code_a = 4'd0;
    endcase
    raw_a = $signed({2'b00, code_a, 2'b00}) + $signed({3'b000, rc_a, 1'b0})
          + $signed({{3{s_a[27]}}, s_a[27:24], 1'b0}) + $signed({7'd0, s_a[28]});
    if (code_a == 4'd0) begin
      rate_a = 6'd0;
    end else if (code_a == 4'd15) begin
      rate_a = 6'd63;
    end else if (rc_a == 4'd15) begin
      rate_a = {code_a, 2'b00};
    end else if (raw_a < 0) begin
      rate_a = 6'd0;
    end else if (raw_a > 8'sd63) begin
      rate_a = 6'd63;
    end else begin
      rate_a = raw_a[5:0];
    end
  end

  always_comb begin
    shift_b  = (rate_r < 6'd48) ? (4'd12 - rate_r[5:2]) : 4'd0;
    mask_b   = (wteg_pkg::EG_CNT_W'(1) << shift_b) - wteg_pkg::EG_CNT_W'(1);
    cnt_sh_b = cnt_r >> shift_b;
    sel_b    = cnt_sh_b[2:0];
    r_m52_b  = rate_r - 6'd52;
    if (rate_r < 6'd52) begin
      row_b = {2'b00, rate_r[1:0]};
    end else if (rate_r < 6'd60) begin
      row_b = 4'd4 + {1'b0, r_m52_b[2:0]};
    end else begin
      row_b = 4'd12;
    end
    inc_b  = wteg_pkg::INC_TABLE[{row_b, sel_b}];
    inc2_b = {inc_b, 1'b0};
    hold_b = (rate_r < 6'd4) || ((cnt_r & mask_b) != '0);

    vp1_b  = {1'b0, att_b_r} + 10'd1;
    prod_b = 13'(vp1_b) * 13'(inc2_b);
    dec_b  = 10'((prod_b + 13'd7) >> 3);
    add_b  = {1'b0, att_b_r} + 10'(inc2_b);

    att_nxt = att_b_r;
    ph_nxt  = ph_b_r;
    act_nxt = act_b_r;
    if (!hold_b) begin
      case (ph_b_r)
        wteg_pkg::PH_ATTACK: begin
          if (dec_b >= {1'b0, att_b_r}) begin
            att_nxt = '0;
            ph_nxt  = wteg_pkg::PH_DECAY;
          end else begin
            att_nxt = att_b_r - dec_b[wteg_pkg::ATT_W-1:0];
          end
        end
        wteg_pkg::PH_DECAY: begin
          att_nxt = (add_b > {1'b0, wteg_pkg::MAX_ATTEN}) ? wteg_pkg::MAX_ATTEN
                                                          : add_b[wteg_pkg::ATT_W-1:0];
          if (att_nxt >= lvl_b_r) begin
            ph_nxt = wteg_pkg::PH_SUSTAIN;
          end
        end
        wteg_pkg::PH_SUSTAIN, wteg_pkg::PH_RELEASE: begin
          if (add_b >= {1'b0, wteg_pkg::MAX_ATTEN}) begin
            att_nxt = wteg_pkg::MAX_ATTEN;
            act_nxt = 1'b0;
          end else begin
            att_nxt = add_b[wteg_pkg::ATT_W-1:0];
          end
        end
        default: begin
          att_nxt = att_b_r;
        end
      endcase
    end
  end

  // Slot state: stage B writes back during a sweep, store and key items write when idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wteg_pkg::NUM_SLOTS; i++) begin
        set_r[i]    <= '0;
        atten_r[i]  <= wteg_pkg::MAX_ATTEN;
        phase_r[i]  <= wteg_pkg::PH_OFF;
        active_r[i] <= 1'b0;
      end
      cnt_r <= '0;
    end else begin
      if (cmd.tick) begin
        cnt_r <= cnt_r + 1'b1;
      end
      for (int i = 0; i < wteg_pkg::NUM_SLOTS; i++) begin
        if (cmd.b_step && idx_b_r == wteg_pkg::SLOT_W'(i)) begin
          atten_r[i]  <= att_nxt;
          phase_r[i]  <= ph_nxt;
          active_r[i] <= act_nxt;
        end else if (cmd.addr == wteg_pkg::SLOT_W'(i)) begin
          if (cmd.store) begin
            set_r[i] <= in_settings;
          end
          if (cmd.key_on) begin
            active_r[i] <= 1'b1;
            phase_r[i]  <= wteg_pkg::PH_ATTACK;
          end
          if (cmd.key_off && active_r[i]) begin
            phase_r[i] <= wteg_pkg::PH_RELEASE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.a_load) begin
      idx_b_r <= cmd.addr;
      rate_r  <= rate_a;
      ph_b_r  <= ph_a;
      att_b_r <= atten_r[cmd.addr];
      lvl_b_r <= wteg_pkg::decay_level(s_a[11:8]);
      act_b_r <= active_r[cmd.addr];
    end
    if (cmd.b_step) begin
      o_slot_r <= 5'(idx_b_r);
      o_att_r  <= att_nxt;
      o_ph_r   <= ph_nxt;
      o_act_r  <= act_nxt;
      o_last_r <= (idx_b_r == wteg_pkg::LAST_SLOT);
    end
  end

  assign out_slot   = o_slot_r;
  assign out_atten  = o_att_r;
  assign out_phase  = o_ph_r;
  assign out_active = o_act_r;
  assign out_last   = o_last_r;

endmodule

// ===== rtl/wavetable_envelope_generator.sv =====
// An envelope tick (kind 0 on in_tuser) first advances the 15-bit envelope counter and
// then steps every slot through a two-stage pipeline, one slot per cycle while the result
// side accepts: the first stage reads the slot and works out its effective rate, the second
// applies the increment and writes the slot back. After a tick is taken in_tready stays low
// until the sweep through all slots ends, which lasts longer while the result side holds
// off; a tick yields one result word per slot, in slot order, with tlast on the final slot.
// Store, key-on and key-off words give no result and leave in_tready high. Input is taken
// only between ticks.
// Top level of the wavetable envelope generator.
// Depends on wteg_pkg, wteg_ctrl and wteg_dp.
module wavetable_envelope_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: slot[4:0], attack_rate[8:5], decay1_rate[12:9],
  // decay_level_code[16:13], decay2_rate[20:17], rate_correction[24:21],
  // release_rate[28:25], octave[32:29], fnum_high_bit[33], zero fill
  input  logic [39:0] in_tdata,
  // tuser from bit 0: mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0: out_slot[4:0], attenuation[13:5], phase[16:14],
  // voice_active[17], zero fill
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  wteg_pkg::wteg_cmd_t          cmd;
  logic [4:0]                   res_slot;
  logic [wteg_pkg::ATT_W-1:0]   res_atten;
  logic [2:0]                   res_phase;
  logic                         res_active;

  wteg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .in_slot    (in_tdata[4:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // The settings fields already sit in tdata in their stored order.
  wteg_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_settings (in_tdata[33:5]),
    .out_slot    (res_slot),
    .out_atten   (res_atten),
    .out_phase   (res_phase),
    .out_active  (res_active),
    .out_last    (out_tlast)
  );

  assign out_tdata = {6'd0, res_active, res_phase, res_atten, res_slot};

endmodule

// ===== rtl/wteg_chk.sv =====
// Port-level checker for the wavetable envelope generator, bound to the
// top level. Depends on wteg_pkg.
module wteg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // A result word that is not taken must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // A tick occupies the block for its sweep.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == wteg_pkg::MODE_TICK |=> !in_tready)
    else $error("input accepted straight after a tick");

  // Other words do not stall the input.
  a_cmd_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != wteg_pkg::MODE_TICK |=> in_tready)
    else $error("input stalled after a non-tick word");

  // tlast marks the final slot.
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[4:0] == 5'(wteg_pkg::NUM_SLOTS - 1))
    else $error("tlast on the wrong slot");

  // Only the five defined phases are reported.
  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:14] <= wteg_pkg::PH_ATTACK)
    else $error("undefined phase code reported");

endmodule

bind wavetable_envelope_generator wteg_chk u_wteg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the wavetable envelope generator: a scoreboard class predicts
// every slot report, a plain task drives the input stream and an initial block the result ready.
// Depends on wteg_pkg and the wavetable_envelope_generator top level.

// Rate settings of one slot, laid out exactly as in in_tdata[33:5].
typedef struct packed {
  logic              fhi;
  logic signed [3:0] oct;
  logic [3:0]        rr;
  logic [3:0]        rc;
  logic [3:0]        d2r;
  logic [3:0]        dl;
  logic [3:0]        d1r;
  logic [3:0]        ar;
} slot_rates_t;

class envelope_scoreboard;

  typedef struct packed {
    logic [4:0] slot;
    logic [8:0] atten;
    logic [2:0] phase;
    logic       active;
    logic       tlast_bit;
  } env_report_t;

  logic [14:0] env_count;
  logic [8:0]  atten [wteg_pkg::NUM_SLOTS];
  logic [2:0]  phase [wteg_pkg::NUM_SLOTS];
  logic        active [wteg_pkg::NUM_SLOTS];
  slot_rates_t rates [wteg_pkg::NUM_SLOTS];

  env_report_t expected_reports [$];
  int mismatches;
  int reports_checked;
  int ticks;
  int stores;
  int key_events;

  function new();
    env_count = '0;
    for (int i = 0; i < wteg_pkg::NUM_SLOTS; i++) begin
      atten[i]  = 9'd511;
      phase[i]  = wteg_pkg::PH_OFF;
      active[i] = 1'b0;
      rates[i]  = '0;
    end
    mismatches = 0;
    reports_checked = 0;
    ticks = 0;
    stores = 0;
    key_events = 0;
  endfunction

  // Increment rows packed as eight nibbles, step 0 in the lowest nibble.
  function int unsigned step_increment(int unsigned row, int unsigned step);
    logic [31:0] pattern;
    case (row)
      0:       pattern = 32'h1010_1010;
      1:       pattern = 32'h1011_1010;
      2:       pattern = 32'h1110_1110;
      3:       pattern = 32'h1111_1110;
      4:       pattern = 32'h1111_1111;
      5:       pattern = 32'h2111_2111;
      6:       pattern = 32'h2121_2121;
      7:       pattern = 32'h2221_2221;
      8:       pattern = 32'h2222_2222;
      9:       pattern = 32'h4222_4222;
      10:      pattern = 32'h4242_4242;
      11:      pattern = 32'h4442_4442;
      default: pattern = 32'h4444_4444;
    endcase
    return pattern[step*4 +: 4];
  endfunction

  function int effective_rate(slot_rates_t r, logic [3:0] code);
    int res;
    if (code == 4'd0) return 0;
    if (code == 4'd15) return 63;
    res = 4 * int'(code);
    if (r.rc != 4'd15) begin
      res += 2 * (int'($signed(r.oct)) + int'(r.rc)) + int'(r.fhi);
    end
    if (res < 0) res = 0;
    if (res > 63) res = 63;
    return res;
  endfunction

  function int decay_target(logic [3:0] code);
    return (code == 4'd15) ? 496 : 16 * int'(code);
  endfunction

  function void advance_slot(int i);
    logic [3:0] code;
    int rate;
    int shift;
    int row;
    int inc;
    int v;
    int dec;
    case (phase[i])
      wteg_pkg::PH_ATTACK:  code = rates[i].ar;
      wteg_pkg::PH_DECAY:   code = rates[i].d1r;
      wteg_pkg::PH_SUSTAIN: code = rates[i].d2r;
      wteg_pkg::PH_RELEASE: code = rates[i].rr;
      default:              return;
    endcase
    rate = effective_rate(rates[i], code);
    if (rate < 4) return;
    shift = (rate < 48) ? 12 - rate / 4 : 0;
    if ((int'(env_count) & ((1 << shift) - 1)) != 0) return;
    if (rate < 52) row = rate & 3;
    else if (rate < 60) row = 4 + ((rate - 52) & 7);
    else row = 12;
    inc = step_increment(row, (int'(env_count) >> shift) & 7);
    v = int'(atten[i]);
    if (phase[i] == wteg_pkg::PH_ATTACK) begin
      // Exponential approach: the step is proportional to the current attenuation.
      dec = ((v + 1) * 2 * inc + 7) >> 3;
      if (dec >= v) begin
        v = 0;
        phase[i] = wteg_pkg::PH_DECAY;
      end else begin
        v -= dec;
      end
    end else if (phase[i] == wteg_pkg::PH_DECAY) begin
      v += 2 * inc;
      if (v > 511) v = 511;
      if (v >= decay_target(rates[i].dl)) phase[i] = wteg_pkg::PH_SUSTAIN;
    end else begin
      v += 2 * inc;
      if (v >= 511) begin
        v = 511;
        active[i] = 1'b0;
      end
    end
    atten[i] = 9'(v);
  endfunction

  function void note_word(logic [1:0] mode, logic [39:0] data);
    logic [4:0] slot;
    env_report_t rep;
    slot = data[4:0];
    if (mode == wteg_pkg::MODE_TICK) begin
      ticks++;
      env_count = env_count + 15'd1;
      for (int i = 0; i < wteg_pkg::NUM_SLOTS; i++) begin
        advance_slot(i);
        rep.slot      = 5'(i);
        rep.atten     = atten[i];
        rep.phase     = phase[i];
        rep.active    = active[i];
        rep.tlast_bit = (i == wteg_pkg::NUM_SLOTS - 1);
        expected_reports.push_back(rep);
      end
      return;
    end
    if (int'(slot) >= wteg_pkg::NUM_SLOTS) return;
    case (mode)
      wteg_pkg::MODE_STORE: begin
        stores++;
        rates[slot] = slot_rates_t'(data[33:5]);
      end
      wteg_pkg::MODE_KEY_ON: begin
        key_events++;
        active[slot] = 1'b1;
        phase[slot]  = wteg_pkg::PH_ATTACK;
      end
      default: begin
        key_events++;
        if (active[slot]) phase[slot] = wteg_pkg::PH_RELEASE;
      end
    endcase
  endfunction

  function void check_report(logic [23:0] word, logic tlast);
    env_report_t got;
    env_report_t want;
    got = {word[4:0], word[13:5], word[16:14], word[17], tlast};
    if (expected_reports.size() == 0) begin
      if (mismatches < 10) begin
        $display("[%0t] unexpected report: slot %0d atten %0d phase %0d active %0d last %0d",
                 $time, got.slot, got.atten, got.phase, got.active, got.tlast_bit);
      end
      mismatches++;
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("[%0t] report mismatch: expected slot %0d atten %0d phase %0d active %0d last %0d",
                 $time, want.slot, want.atten, want.phase, want.active, want.tlast_bit);
        $display("            got slot %0d atten %0d phase %0d active %0d last %0d",
                 got.slot, got.atten, got.phase, got.active, got.tlast_bit);
      end
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

endclass

module testbench;

  localparam int RANDOM_WORDS = 305;
  localparam int LONG_HOLD    = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;

  envelope_scoreboard sb;
  bit idle_on;
  bit long_hold_req;

  wavetable_envelope_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic logic [39:0] pack_word(logic [4:0] slot, slot_rates_t r);
    return {6'b0, r, slot};
  endfunction

  function automatic slot_rates_t make_rates(int ar, int d1r, int dl, int d2r, int rc, int rr,
                                              int oct, int fhi);
    slot_rates_t r;
    r.ar  = 4'(ar);
    r.d1r = 4'(d1r);
    r.dl  = 4'(dl);
    r.d2r = 4'(d2r);
    r.rc  = 4'(rc);
    r.rr  = 4'(rr);
    r.oct = 4'(oct);
    r.fhi = 1'(fhi);
    return r;
  endfunction

  // Mostly fast rates so that envelopes travel far within the run.
  function automatic slot_rates_t random_rates();
    slot_rates_t r;
    r = 29'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      r.ar  = 4'($urandom_range(8, 15));
      r.d1r = 4'($urandom_range(8, 15));
      r.d2r = 4'($urandom_range(8, 15));
      r.rr  = 4'($urandom_range(8, 15));
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [1:0] mode, input logic [39:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(mode, data);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      sb.check_report(out_tdata, out_tlast);
    end
  end

  initial begin : result_sink
    int burst;
    int hold_left;
    burst = 0;
    hold_left = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (burst == 0 && idle_on && $urandom_range(0, 5) == 0) begin
          burst = $urandom_range(1, 5);
        end
        if (burst > 0) begin
          burst--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout: the run did not complete");
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [4:0] slot;
    logic [1:0] mode;
    int pick;
    int sent;
    bit hold_done;

    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = wteg_pkg::MODE_TICK;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    hold_done = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, ignored slots and each phase transition.
    send_word(wteg_pkg::MODE_TICK, {6'b0, 29'h1FFF_FFFF, 5'd31});
    send_word(wteg_pkg::MODE_STORE, pack_word(5'd0, make_rates(15, 15, 15, 15, 15, 15, -8, 1)));
    send_word(wteg_pkg::MODE_STORE, pack_word(5'd1, make_rates(1, 14, 0, 0, 0, 1, -8, 0)));
    send_word(wteg_pkg::MODE_STORE, pack_word(5'd2, make_rates(14, 13, 1, 12, 14, 14, 7, 1)));
    send_word(wteg_pkg::MODE_STORE, pack_word(5'd23, make_rates(11, 10, 14, 11, 0, 13, 0, 1)));
    send_word(wteg_pkg::MODE_STORE, pack_word(5'd24, make_rates(15, 15, 15, 15, 0, 15, 7, 1)));
    send_word(wteg_pkg::MODE_KEY_ON, pack_word(5'd31, '0));
    send_word(wteg_pkg::MODE_KEY_OFF, pack_word(5'd3, '0));
    send_word(wteg_pkg::MODE_KEY_ON, pack_word(5'd0, '0));
    send_word(wteg_pkg::MODE_KEY_ON, pack_word(5'd1, '0));
    send_word(wteg_pkg::MODE_KEY_ON, pack_word(5'd2, '0));
    send_word(wteg_pkg::MODE_KEY_ON, pack_word(5'd23, '0));
    repeat (6) send_word(wteg_pkg::MODE_TICK, pack_word(5'd0, '0));
    send_word(wteg_pkg::MODE_KEY_OFF, pack_word(5'd0, '0));
    send_word(wteg_pkg::MODE_KEY_OFF, pack_word(5'd2, '0));
    repeat (4) send_word(wteg_pkg::MODE_TICK, pack_word(5'd0, '0));
    send_word(wteg_pkg::MODE_KEY_ON, pack_word(5'd0, '0));

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      // A quiet window in the middle, and none at all over the closing stretch.
      idle_on = (sent < 140 || sent >= 170) && sent < RANDOM_WORDS - 40;
      if (sent == 60 && !hold_done) begin
        hold_done = 1'b1;
        long_hold_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      slot = 5'($urandom_range(0, wteg_pkg::NUM_SLOTS - 1));
      if (pick < 45) begin
        send_word(wteg_pkg::MODE_TICK, pack_word(5'($urandom), random_rates()));
        sent++;
      end else begin
        if ($urandom_range(0, 9) == 0) slot = 5'($urandom_range(wteg_pkg::NUM_SLOTS, 31));
        if (pick < 65) mode = wteg_pkg::MODE_STORE;
        else if (pick < 85) mode = wteg_pkg::MODE_KEY_ON;
        else mode = wteg_pkg::MODE_KEY_OFF;
        send_word(mode, pack_word(slot, random_rates()));
        if (int'(slot) < wteg_pkg::NUM_SLOTS) sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d ticks, %0d setting stores and %0d key events; %0d slot reports checked",
             sb.ticks, sb.stores, sb.key_events, sb.reports_checked);
    $display("%0d mismatches, %0d reports outstanding", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
